// ===== hw/rtl/iesf_pkg.sv =====
`default_nettype none
package iesf_pkg;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_CLEAR  = 2'd1,
    FUNC_TEXT   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_DECIDE
  } state_t;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // Broadcast control that every cell of the chain sees in the same cycle.
  typedef struct packed {
    logic       clear_marks;
    logic       restart;
    logic       text_en;
    logic [7:0] text_byte;
    logic       wr_en;
    logic [7:0] wr_data;
    logic       mark_en;
    logic       mark_excl;
  } cell_ctl_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/iesf_cell.sv =====
`default_nettype none
module iesf_cell #(
  parameter int IW  = 8,
  parameter int IDX = 0
) (
  input  wire                   clk,
  input  wire                   rst,
  input  iesf_pkg::cell_ctl_t   ctl,
  input  wire  [IW-1:0]         wr_idx,
  input  wire  [IW-1:0]         mark_lo,
  input  wire  [IW-1:0]         mark_hi,
  input  wire                   left_prefix,
  input  wire                   left_dec_valid,
  input  wire                   left_dec_pass,
  output logic                  prefix,
  output logic                  dec_valid,
  output logic                  dec_pass
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [7:0] ch;
  logic       m_start;
  logic       m_cont;
  logic       m_end;
  logic       excl;
  logic       found;
  logic       bit_next;

  always_comb begin
    bit_next = (m_start || m_cont)
               && (iesf_pkg::fold(ch) == iesf_pkg::fold(ctl.text_byte))
               && (m_start || left_prefix);
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && wr_idx == MY_IDX) begin
      ch <= ctl.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear_marks) begin
      m_start <= 1'b0;
      m_cont  <= 1'b0;
      m_end   <= 1'b0;
      excl    <= 1'b0;
    end else if (ctl.mark_en) begin
      if (mark_lo == MY_IDX) begin
        m_start <= 1'b1;
      end
      if (MY_IDX > mark_lo && MY_IDX <= mark_hi) begin
        m_cont <= 1'b1;
      end
      if (mark_hi == MY_IDX) begin
        m_end <= 1'b1;
        excl  <= ctl.mark_excl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      prefix <= 1'b0;
      found  <= 1'b0;
    end else if (ctl.text_en) begin
      prefix <= bit_next;
      if (m_end && bit_next) begin
        found <= 1'b1;
      end
    end
  end

  // The earliest found term wins; its verdict ripples down one cell a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
      dec_pass  <= 1'b0;
    end else if (left_dec_valid) begin
      dec_valid <= 1'b1;
      dec_pass  <= left_dec_pass;
    end else begin
      dec_valid <= m_end && found;
      dec_pass  <= !excl;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/iesf_chain.sv =====
`default_nettype none
module iesf_chain #(
  parameter int N  = 256,
  parameter int IW = 8
) (
  input  wire                   clk,
  input  wire                   rst,
  input  iesf_pkg::cell_ctl_t   ctl,
  input  wire  [IW-1:0]         wr_idx,
  input  wire  [IW-1:0]         mark_lo,
  input  wire  [IW-1:0]         mark_hi,
  output logic                  dec_valid,
  output logic                  dec_pass
);

  logic [N-1:0] pre;
  logic [N-1:0] dv;
  logic [N-1:0] dp;

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      logic lp;
      logic ldv;
      logic ldp;
      if (i == 0) begin : g_first
        assign lp  = 1'b0;
        assign ldv = 1'b0;
        assign ldp = 1'b0;
      end else begin : g_rest
        assign lp  = pre[i-1];
        assign ldv = dv[i-1];
        assign ldp = dp[i-1];
      end
      iesf_cell #(.IW(IW), .IDX(i)) u_cell (
        .clk            (clk),
        .rst            (rst),
        .ctl            (ctl),
        .wr_idx         (wr_idx),
        .mark_lo        (mark_lo),
        .mark_hi        (mark_hi),
        .left_prefix    (lp),
        .left_dec_valid (ldv),
        .left_dec_pass  (ldp),
        .prefix         (pre[i]),
        .dec_valid      (dv[i]),
        .dec_pass       (dp[i])
      );
    end
  endgenerate

  assign dec_valid = dv[N-1];
  assign dec_pass  = dp[N-1];

endmodule
`default_nettype wire

// ===== hw/rtl/include_exclude_substring_filter_core.sv =====
`default_nettype none
// Text byte without tlast: the next byte may follow at once.
// Last text byte of a line: the result word follows once the verdict has rippled
// through the chain of per-character cells and the output register is free.
// Filter append or clear: the term marks are rebuilt from the filter memory.
// Synchronous reset empties the filter and clears all marks and match state.
module include_exclude_substring_filter_core #(
  parameter int FILTER_LEN = 256,
  parameter int MAX_TERMS  = 128
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // [7:0] data_byte
  input  wire  [1:0] s_tuser,   // [1:0] func
  input  wire        s_tlast,   // last_byte
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata    // [0] line_passes, [1] filter_active, [7:2] zero
);

  localparam int IW = $clog2(FILTER_LEN);
  localparam int TW = $clog2(MAX_TERMS + 1);
  localparam int CW = $clog2(FILTER_LEN + 1);
  localparam logic [IW-1:0] LEN_MAX   = IW'(FILTER_LEN - 1);
  localparam logic [TW-1:0] TERMS_MAX = TW'(MAX_TERMS);
  localparam logic [CW-1:0] DEC_WAIT  = CW'(FILTER_LEN);

  iesf_pkg::state_t  state;
  iesf_pkg::state_t  state_next;
  iesf_pkg::cell_ctl_t ctl;

  logic [7:0]    mem [FILTER_LEN];
  logic [7:0]    mem_q;
  logic [IW-1:0] len;
  logic          term;
  logic [7:0]    inc_count;
  logic [IW-1:0] rp;
  logic          s_valid;
  logic [IW-1:0] s_idx;
  logic          seg_on;
  logic [IW-1:0] seg_b;
  logic          seg_excl;
  logic [IW-1:0] last_nb;
  logic [TW-1:0] terms;
  logic [CW-1:0] dcnt;
  logic          out_valid;
  logic          out_pass;
  logic          out_active;

  logic          accept;
  logic [1:0]    func;
  logic          do_append;
  logic          rd_en;
  logic          sweep_done;
  logic          fin;
  logic          emit_term;
  logic          is_blank;
  logic          emit;
  logic [IW-1:0] mark_lo;
  logic          dec_valid;
  logic          dec_pass;

  assign func      = s_tuser;
  assign accept    = s_tvalid && s_tready;
  assign do_append = (func == iesf_pkg::FUNC_APPEND) && !term && len < LEN_MAX
                     && s_tdata != 8'd0;
  assign rd_en      = (state == iesf_pkg::ST_BUILD) && rp < len;
  assign sweep_done = (state == iesf_pkg::ST_BUILD) && rp == len && !s_valid;
  assign is_blank   = mem_q == iesf_pkg::CH_SPACE || mem_q == iesf_pkg::CH_TAB;
  assign fin        = (s_valid && mem_q == iesf_pkg::CH_COMMA) || sweep_done;
  assign emit_term  = fin && seg_on && !(seg_excl && last_nb == seg_b)
                      && terms < TERMS_MAX;
  assign mark_lo    = seg_excl ? seg_b + IW'(1) : seg_b;
  assign emit       = (state == iesf_pkg::ST_DECIDE) && dcnt == DEC_WAIT
                      && (!out_valid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      iesf_pkg::ST_IDLE: begin
        if (accept) begin
          if (func == iesf_pkg::FUNC_APPEND || func == iesf_pkg::FUNC_CLEAR) begin
            state_next = iesf_pkg::ST_BUILD;
          end else if (func == iesf_pkg::FUNC_TEXT && s_tlast) begin
            state_next = iesf_pkg::ST_DECIDE;
          end
        end
      end
      iesf_pkg::ST_BUILD: begin
        if (sweep_done) begin
          state_next = iesf_pkg::ST_IDLE;
        end
      end
      iesf_pkg::ST_DECIDE: begin
        if (emit) begin
          state_next = iesf_pkg::ST_IDLE;
        end
      end
      default: state_next = iesf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = state == iesf_pkg::ST_IDLE;
    ctl.clear_marks = accept && (func == iesf_pkg::FUNC_APPEND
                                 || func == iesf_pkg::FUNC_CLEAR);
    ctl.restart   = ctl.clear_marks || emit;
    ctl.text_en   = accept && func == iesf_pkg::FUNC_TEXT;
    ctl.text_byte = s_tdata;
    ctl.wr_en     = accept && do_append;
    ctl.wr_data   = s_tdata;
    ctl.mark_en   = emit_term;
    ctl.mark_excl = seg_excl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iesf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && do_append) begin
      mem[len] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= '0;
      term <= 1'b0;
    end else if (accept && func == iesf_pkg::FUNC_CLEAR) begin
      len  <= '0;
      term <= 1'b0;
    end else if (accept && func == iesf_pkg::FUNC_APPEND && !term && len < LEN_MAX) begin
      if (s_tdata == 8'd0) begin
        term <= 1'b1;
      end else begin
        len <= len + IW'(1);
      end
    end
  end

  // Mark rebuild: one filter character per cycle from the memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      rp        <= '0;
      s_valid   <= 1'b0;
      seg_on    <= 1'b0;
      terms     <= '0;
      inc_count <= '0;
    end else if (ctl.clear_marks) begin
      rp        <= '0;
      s_valid   <= 1'b0;
      seg_on    <= 1'b0;
      terms     <= '0;
      inc_count <= '0;
    end else if (state == iesf_pkg::ST_BUILD) begin
      s_valid <= rd_en;
      s_idx   <= rp;
      if (rd_en) begin
        rp <= rp + IW'(1);
      end
      if (emit_term) begin
        terms <= terms + TW'(1);
        if (!seg_excl && inc_count != 8'hFF) begin
          inc_count <= inc_count + 8'd1;
        end
      end
      if (fin) begin
        seg_on <= 1'b0;
      end else if (s_valid && !is_blank) begin
        if (!seg_on) begin
          seg_on   <= 1'b1;
          seg_b    <= s_idx;
          seg_excl <= mem_q == iesf_pkg::CH_MINUS;
        end
        last_nb <= s_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (accept) begin
      dcnt <= '0;
    end else if (state == iesf_pkg::ST_DECIDE && dcnt != DEC_WAIT) begin
      dcnt <= dcnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pass   <= dec_valid ? dec_pass : (inc_count == 8'd0);
      out_active <= len != '0;
    end
  end

  iesf_chain #(.N(FILTER_LEN), .IW(IW)) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .wr_idx    (len),
    .mark_lo   (mark_lo),
    .mark_hi   (last_nb),
    .dec_valid (dec_valid),
    .dec_pass  (dec_pass)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_active, out_pass};

endmodule
`default_nettype wire

// ===== tb/tb_include_exclude_substring_filter_core.sv =====
`timescale 1ns / 1ps
module tb_include_exclude_substring_filter_core;

  localparam int FLEN   = 256;
  localparam int NTERMS = 128;
  localparam int LIMIT  = 40000;
  localparam logic [2:0] MK_START = 3'd1;
  localparam logic [2:0] MK_CONT  = 3'd2;
  localparam logic [2:0] MK_END   = 3'd4;

  typedef struct packed {
    iesf_pkg::func_t func;
    logic [7:0]      data;
    logic            last;
  } word_t;

  typedef struct packed {
    logic passes;
    logic active;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic [1:0] s_tuser = 2'd0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  include_exclude_substring_filter_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),   // [7:0] data_byte
    .s_tuser (s_tuser),   // [1:0] func
    .s_tlast (s_tlast),   // last_byte
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)    // [0] line_passes, [1] filter_active
  );

  always #6 clk = ~clk;

  // Shadow of the filter state.
  logic [7:0] flt_chars [FLEN];
  int         flt_len;
  logic       flt_term;
  logic [2:0] marks [FLEN];
  logic       prefix [FLEN];
  logic       found [NTERMS];
  int         n_incl;

  word_t    pending_words[$];
  verdict_t verdicts_due[$];
  int       n_errors, n_lines, n_sent, n_passed, idle_cycles;
  logic     hold_sink, drain_req;
  logic     in_acc = 1'b0;

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
  endfunction

  function automatic logic blank(logic [7:0] c);
    return c == iesf_pkg::CH_SPACE || c == iesf_pkg::CH_TAB;
  endfunction

  function automatic void restart_scan();
    foreach (prefix[i]) prefix[i] = 1'b0;
    foreach (found[i]) found[i] = 1'b0;
  endfunction

  function automatic void build_marks();
    int seg, e, b, nxt, body, terms;
    logic excl;
    seg = 0;
    terms = 0;
    n_incl = 0;
    foreach (marks[i]) marks[i] = 3'd0;
    while (seg < flt_len) begin
      e = seg;
      b = seg;
      while (e < flt_len && flt_chars[e] != iesf_pkg::CH_COMMA) e++;
      nxt = e + 1;
      while (b < e && blank(flt_chars[b])) b++;
      while (e > b && blank(flt_chars[e-1])) e--;
      seg = nxt;
      if (b != e) begin
        excl = flt_chars[b] == iesf_pkg::CH_MINUS;
        body = excl ? b + 1 : b;
        if (body != e && terms < NTERMS) begin
          marks[body] = MK_START;
          for (int p = body + 1; p < e; p++) marks[p] = MK_CONT;
          marks[e-1] |= MK_END;
          terms++;
          if (!excl && n_incl < 255) n_incl++;
        end
      end
    end
  endfunction

  function automatic void filter_step(word_t w);
    logic       old [FLEN];
    logic       bit_v, prev, decided, pass;
    int         idx, start;
    verdict_t   v;
    if (w.func == iesf_pkg::FUNC_APPEND || w.func == iesf_pkg::FUNC_CLEAR) begin
      if (w.func == iesf_pkg::FUNC_CLEAR) begin
        flt_len = 0;
        flt_term = 1'b0;
      end else if (!flt_term && flt_len < FLEN - 1) begin
        if (w.data == 8'd0) flt_term = 1'b1;
        else begin
          flt_chars[flt_len] = w.data;
          flt_len++;
        end
      end
      build_marks();
      restart_scan();
      return;
    end
    if (w.func != iesf_pkg::FUNC_TEXT) return;
    old = prefix;
    idx = 0;
    for (int p = 0; p < flt_len; p++) begin
      bit_v = 1'b0;
      if (marks[p] & (MK_START | MK_CONT)) begin
        prev = (marks[p] & MK_START) ? 1'b1 : (p > 0 && old[p-1]);
        bit_v = (upcase(flt_chars[p]) == upcase(w.data)) && prev;
      end
      prefix[p] = bit_v;
      if (marks[p] & MK_END) begin
        if (bit_v && idx < NTERMS) found[idx] = 1'b1;
        idx++;
      end
    end
    if (!w.last) return;
    idx = 0;
    start = 0;
    decided = 1'b0;
    pass = 1'b0;
    for (int p = 0; p < flt_len && !decided; p++) begin
      if (marks[p] & MK_START) start = p;
      if (marks[p] & MK_END) begin
        if (idx < NTERMS && found[idx]) begin
          pass = !(start > 0 && flt_chars[start-1] == iesf_pkg::CH_MINUS);
          decided = 1'b1;
        end
        idx++;
      end
    end
    if (!decided) pass = n_incl == 0;
    v = '{passes: pass, active: flt_len != 0};
    verdicts_due.insert(verdicts_due.size(), v);
    restart_scan();
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    $display("mismatch on line %0d: %s got %0b want %0b", n_lines, what, got, want);
    n_errors++;
  endtask

  // Input handshakes are taken at the rising edge; the driver acts on them later.
  always @(posedge clk) begin
    in_acc <= s_tvalid && s_tready;
  end

  // Driver: one word per handshake, random gaps, optional drain pause.
  int src_gap;
  always @(negedge clk) begin
    word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else if (!s_tvalid || in_acc) begin
      if (in_acc) n_sent++;
      if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_words.size() > 0
                   && pending_words[0].func == iesf_pkg::FUNC_NONE
                   && pending_words[0].data == 8'hFF && pending_words[0].last
                   && !drain_req) begin
        // Marker word: wait until every verdict has been taken.
        s_tvalid <= 1'b0;
        if (verdicts_due.size() == 0) void'(pending_words.pop_front());
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        s_tuser  <= w.func;
        s_tdata  <= w.data;
        s_tlast  <= w.last;
        s_tvalid <= 1'b1;
        filter_step(w);
        src_gap = gap_len();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  int sink_gap, hold_left;
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap = 0;
      hold_left = 0;
    end else if (hold_sink && hold_left == 0 && n_lines == 20) begin
      hold_left = 3000;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_sink <= 1'b0;
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      sink_gap = gap_len();
    end
  end

  // Monitor.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("unexpected word", m_tdata[0], 1'b0);
        end else begin
          want = verdicts_due.pop_front();
          if (m_tdata[0] !== want.passes) report_mismatch("line_passes", m_tdata[0], want.passes);
          if (m_tdata[1] !== want.active) report_mismatch("filter_active", m_tdata[1], want.active);
          if (want.passes) n_passed++;
        end
        n_lines++;
      end
    end
  end

  function automatic void put(iesf_pkg::func_t f, logic [7:0] d, logic l);
    word_t w;
    w = '{func: f, data: d, last: l};
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic void put_str(iesf_pkg::func_t f, string s, logic end_line);
    for (int i = 0; i < s.len(); i++)
      put(f, s[i], end_line && i == s.len() - 1);
  endfunction

  function automatic logic [7:0] rnd_char();
    string pool = "aBcD";
    case ($urandom_range(0, 9))
      0: return iesf_pkg::CH_COMMA;
      1: return iesf_pkg::CH_MINUS;
      2: return iesf_pkg::CH_SPACE;
      3: return iesf_pkg::CH_TAB;
      4: return 8'($urandom_range(0, 255));
      default: return pool[$urandom_range(0, 3)];
    endcase
  endfunction

  function automatic void random_filter();
    int n;
    put(iesf_pkg::FUNC_CLEAR, 8'($urandom), 1'($urandom));
    n = $urandom_range(0, 9) == 0 ? $urandom_range(40, 270) : $urandom_range(0, 12);
    for (int i = 0; i < n; i++) begin
      logic [7:0] c;
      c = rnd_char();
      if (c == 8'd0 && $urandom_range(0, 3) != 0) c = "a";
      put(iesf_pkg::FUNC_APPEND, c, 1'($urandom));
    end
  endfunction

  function automatic void random_line();
    int n;
    string pool = "aAbBcCdD-, ";
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      logic [7:0] c;
      c = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                    : pool[$urandom_range(0, 10)];
      put(iesf_pkg::FUNC_TEXT, c, i == n - 1);
      if ($urandom_range(0, 80) == 0) put(iesf_pkg::FUNC_NONE, 8'($urandom), 1'($urandom));
    end
  endfunction

  initial begin
    hold_sink = 1'b1;
    drain_req = 1'b0;
    n_errors = 0; n_lines = 0; n_sent = 0; n_passed = 0; idle_cycles = 0;
    flt_len = 0; flt_term = 1'b0;
    foreach (flt_chars[i]) flt_chars[i] = 8'd0;
    build_marks();
    restart_scan();

    // Directed: empty filter, include/exclude, blanks, lone minus, case fold.
    put_str(iesf_pkg::FUNC_TEXT, "abc", 1'b1);
    put_str(iesf_pkg::FUNC_APPEND, " foo ,\t-Bar, -,,", 1'b0);
    put_str(iesf_pkg::FUNC_TEXT, "xFOOx", 1'b1);
    put_str(iesf_pkg::FUNC_TEXT, "bar foo", 1'b1);
    put_str(iesf_pkg::FUNC_TEXT, "zz", 1'b1);
    put(iesf_pkg::FUNC_NONE, 8'hA5, 1'b1);
    put(iesf_pkg::FUNC_CLEAR, 8'hFF, 1'b1);
    put_str(iesf_pkg::FUNC_APPEND, "-", 1'b0);
    put_str(iesf_pkg::FUNC_TEXT, "-q", 1'b1);
    put(iesf_pkg::FUNC_APPEND, 8'h00, 1'b0);
    put(iesf_pkg::FUNC_APPEND, 8'hFF, 1'b1);
    put(iesf_pkg::FUNC_TEXT, 8'hFF, 1'b0);
    put(iesf_pkg::FUNC_APPEND, "x", 1'b0);
    put(iesf_pkg::FUNC_TEXT, 8'h00, 1'b1);
    // Sender pauses here until every verdict is back.
    put(iesf_pkg::FUNC_NONE, 8'hFF, 1'b1);

    // Random: filters of mostly short length, with lines between.
    while (pending_words.size() < 1540) begin
      random_filter();
      repeat ($urandom_range(1, 8)) random_line();
      if ($urandom_range(0, 9) == 0) put(iesf_pkg::FUNC_APPEND, rnd_char(), 1'b0);
    end
    // Full filter: many terms and overflow past the length limit.
    put(iesf_pkg::FUNC_CLEAR, 8'h00, 1'b0);
    for (int i = 0; i < 300; i++)
      put(iesf_pkg::FUNC_APPEND, (i % 2) ? iesf_pkg::CH_COMMA : 8'("a" + (i % 5)), 1'b0);
    repeat (10) random_line();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_words.size() > 0 || verdicts_due.size() > 0 || s_tvalid) begin
      @(posedge clk);
      if (idle_cycles > LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
    repeat (FLEN * 3) @(posedge clk);
    $display("covered %0d words, %0d lines, %0d passed", n_sent, n_lines, n_passed);
    if (n_errors == 0 && verdicts_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
